@@ design/tli_pkg.sv @@
package tli_pkg;

	localparam int MaxPoints  = 64;
	localparam int IdxW       = 6;
	localparam int CntW       = 7;
	localparam int JointCount = 3;
	localparam int JointW     = 2;
	localparam logic [31:0] TwoPiQ28 = 32'd1686629713;

	localparam logic [1:0] STATUS_NONE = 2'd0;
	localparam logic [1:0] STATUS_SETPOINT = 2'd1;
	localparam logic [1:0] STATUS_DONE = 2'd2;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

endpackage

@@ design/trajectory_linear_interpolator.sv @@
// Channel  | valid     | stall     | payload
// input    | in_valid  | in_stall  | func, point_index, point_last, point_time, point_pos_*, now_time
// output   | out_valid | out_stall | status, segment, setpoint_a, setpoint_b, setpoint_c
//
// A load is written in the ST_LOAD state after it is accepted, one joint position per cycle.
// A tick first searches the waypoint times, reading and comparing one at a time, and a
// completion is ready once the search runs past the last waypoint; otherwise it fetches the
// start time, divides (a clamped weight skips the serial division), and for each joint reads
// the start and end points, multiplies, wraps and stores the result.
// Reset clears the trajectory state only; the memories hold no valid bits.
// A stalled result holds off the next input; input is taken in the cycle the beat moves.
module trajectory_linear_interpolator
	import tli_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                func,
	input  logic [IdxW-1:0]     point_index,
	input  logic                point_last,
	input  logic [31:0]         point_time,
	input  logic signed [31:0]  point_pos_a,
	input  logic signed [31:0]  point_pos_b,
	input  logic signed [31:0]  point_pos_c,
	input  logic [31:0]         now_time,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic [IdxW-1:0]     segment,
	output logic [30:0]         setpoint_a,
	output logic [30:0]         setpoint_b,
	output logic [30:0]         setpoint_c
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_SRCH_RD, ST_SRCH_CMP, ST_T0_RD, ST_T0_GET, ST_DIV,
		ST_POS_RD, ST_POS_GET, ST_MUL, ST_WRAP, ST_OUT
	} state_t;

	// Waypoint memories, one write and one registered read port each.
	logic [31:0] time_mem [MaxPoints];
	logic [31:0] pos_mem [MaxPoints*JointCount];
	logic [31:0] time_rd_q;
	logic [31:0] pos_rd_q;

	state_t         state_q;
	logic [CntW-1:0] count_q;
	logic           active_q, start_valid_q;
	logic [31:0]    start_q, elapsed_q;
	logic [IdxW-1:0] seg_q;
	logic [31:0]    t1_q;
	logic [33:0]    num_q, dur_q;
	logic [34:0]    rem_q;
	logic [30:0]    w_q;
	logic [4:0]     bit_q;
	logic [JointW-1:0] joint_q;
	logic           pos_end_q;
	logic [31:0]    p0_q;
	logic signed [63:0] acc_q;
	logic signed [32:0] diff_q;
	logic [30:0]    wsh_q;
	logic [1:0]     load_joint_q;
	logic [IdxW-1:0] load_idx_q;
	logic [31:0]    load_time_q;
	logic [31:0]    load_pos_q [JointCount];
	logic           load_last_q;
	logic [IdxW-1:0] rd_pt;
	logic [7:0]     rd_addr;
	logic [IdxW-1:0] trd_addr;
	logic [34:0]    div_trial;
	logic signed [33:0] wrap_v;

	assign in_stall = (state_q != ST_IDLE) || (out_valid && out_stall);

	// Time and position reads; address set by the sequencer.
	always_comb begin
		trd_addr = seg_q;
		if (state_q == ST_T0_RD) begin
			trd_addr = seg_q - IdxW'(1);
		end
		rd_pt = pos_end_q ? seg_q : seg_q - IdxW'(1);
		rd_addr = 8'(rd_pt) * 8'(JointCount) + 8'(joint_q);
	end

	// Shifted partial remainder for one quotient bit.
	always_comb begin
		div_trial = (bit_q == 5'd30) ? {1'b0, num_q} << 1 : rem_q << 1;
	end

	// Joint value with the rounded product, wrapped into the positive range.
	always_comb begin
		wrap_v = $signed({{2{p0_q[31]}}, p0_q}) + 34'(acc_q >>> 30);
		if (wrap_v < 0) wrap_v = wrap_v + $signed(34'(TwoPiQ28));
		if (wrap_v < 0) wrap_v = wrap_v + $signed(34'(TwoPiQ28));
	end

	always_ff @(posedge clk) begin
		time_rd_q <= time_mem[trd_addr];
		pos_rd_q <= pos_mem[rd_addr];
		if (state_q == ST_LOAD) begin
			if (load_joint_q == 2'd0) begin
				time_mem[load_idx_q] <= load_time_q;
			end
			pos_mem[8'(32'(load_idx_q) * JointCount + 32'(load_joint_q))] <= load_pos_q[load_joint_q];
		end
	end

	// Sequencer with the search, the serial divider and the serial multiplier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			active_q <= 1'b0;
			start_valid_q <= 1'b0;
			start_q <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
			ST_IDLE: begin
				if (in_valid && !in_stall && func == FUNC_TICK && !active_q) begin
					status <= STATUS_NONE;
					segment <= '0;
					setpoint_a <= '0;
					setpoint_b <= '0;
					setpoint_c <= '0;
					out_valid <= 1'b1;
				end else if (out_valid && !out_stall) begin
					out_valid <= 1'b0;
				end
				if (in_valid && !in_stall) begin
					if (func == FUNC_LOAD) begin
						load_idx_q <= point_index;
						load_time_q <= point_time;
						load_pos_q[0] <= point_pos_a;
						load_pos_q[1] <= point_pos_b;
						load_pos_q[2] <= point_pos_c;
						load_last_q <= point_last;
						load_joint_q <= 2'd0;
						state_q <= ST_LOAD;
					end else if (active_q) begin
						if (!start_valid_q) begin
							start_q <= now_time;
							start_valid_q <= 1'b1;
							elapsed_q <= '0;
						end else begin
							elapsed_q <= now_time - start_q;
						end
						seg_q <= IdxW'(1);
						state_q <= ST_SRCH_RD;
					end
				end
			end
			ST_LOAD: begin
				load_joint_q <= load_joint_q + 2'd1;
				if (load_joint_q == 2'(JointCount - 1)) begin
					if (load_last_q) begin
						count_q <= CntW'(load_idx_q) + CntW'(1);
						active_q <= 1'b1;
						start_valid_q <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
			end
			ST_SRCH_RD: begin
				if (CntW'(seg_q) >= count_q || seg_q == '0) begin
					status <= STATUS_DONE;
					segment <= '0;
					setpoint_a <= '0;
					setpoint_b <= '0;
					setpoint_c <= '0;
					active_q <= 1'b0;
					start_valid_q <= 1'b0;
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end else begin
					state_q <= ST_SRCH_CMP;
				end
			end
			ST_SRCH_CMP: begin
				if (time_rd_q < elapsed_q) begin
					seg_q <= seg_q + IdxW'(1);
					state_q <= ST_SRCH_RD;
				end else begin
					t1_q <= time_rd_q;
					state_q <= ST_T0_RD;
				end
			end
			ST_T0_RD: state_q <= ST_T0_GET;
			ST_T0_GET: begin
				num_q <= {2'b00, elapsed_q} - {2'b00, time_rd_q};
				dur_q <= {2'b00, t1_q} - {2'b00, time_rd_q};
				rem_q <= '0;
				w_q <= '0;
				bit_q <= 5'd30;
				state_q <= ST_DIV;
			end
			ST_DIV: begin
				// One quotient bit a cycle; past the clamps num < dur so the weight is below one.
				if (dur_q[33] || dur_q == '0 || $signed(num_q) >= $signed(dur_q)) begin
					w_q <= 31'h4000_0000;
					joint_q <= '0;
					pos_end_q <= 1'b0;
					state_q <= ST_POS_RD;
				end else if (num_q[33] || num_q == '0) begin
					w_q <= '0;
					joint_q <= '0;
					pos_end_q <= 1'b0;
					state_q <= ST_POS_RD;
				end else begin
					if (div_trial >= {1'b0, dur_q}) begin
						rem_q <= div_trial - {1'b0, dur_q};
						w_q <= {w_q[29:0], 1'b1};
					end else begin
						rem_q <= div_trial;
						w_q <= {w_q[29:0], 1'b0};
					end
					bit_q <= bit_q - 5'd1;
					if (bit_q == 5'd1) begin
						joint_q <= '0;
						pos_end_q <= 1'b0;
						state_q <= ST_POS_RD;
					end
				end
			end
			ST_POS_RD: begin
				// Two reads per joint: the start point, then the end point.
				state_q <= ST_POS_GET;
			end
			ST_POS_GET: begin
				if (!pos_end_q) begin
					p0_q <= pos_rd_q;
					pos_end_q <= 1'b1;
					state_q <= ST_POS_RD;
				end else begin
					diff_q <= $signed({pos_rd_q[31], pos_rd_q}) - $signed({p0_q[31], p0_q});
					acc_q <= 64'sd1 <<< 29;
					wsh_q <= w_q;
					bit_q <= '0;
					pos_end_q <= 1'b0;
					state_q <= ST_MUL;
				end
			end
			ST_MUL: begin
				// Shift-and-add, one weight bit per cycle.
				if (wsh_q[0]) begin
					acc_q <= acc_q + (64'(diff_q) <<< bit_q);
				end
				wsh_q <= wsh_q >> 1;
				bit_q <= bit_q + 5'd1;
				if (bit_q == 5'd30) state_q <= ST_WRAP;
			end
			ST_WRAP: begin
				acc_q <= 64'(wrap_v);
				state_q <= ST_OUT;
			end
			ST_OUT: begin
				case (joint_q)
				2'd0: setpoint_a <= acc_q[30:0];
				2'd1: setpoint_b <= acc_q[30:0];
				default: setpoint_c <= acc_q[30:0];
				endcase
				if (joint_q == 2'(JointCount - 1)) begin
					status <= STATUS_SETPOINT;
					segment <= seg_q;
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end else begin
					joint_q <= joint_q + 2'd1;
					state_q <= ST_POS_RD;
				end
			end
			default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STATUS_SETPOINT) |-> (segment != '0))
		else $error("segment zero on setpoint");

endmodule

@@ tb/sv/tb_trajectory_linear_interpolator.sv @@
module tb_trajectory_linear_interpolator;
	import tli_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  segment;
		logic [30:0] sp_a;
		logic [30:0] sp_b;
		logic [30:0] sp_c;
	} setpoint_t;

	// Tracks the trajectory table and predicts one setpoint beat for each tick.
	class setpoint_scoreboard;
		logic [31:0]        wp_time [MaxPoints];
		logic signed [31:0] wp_pos  [MaxPoints][JointCount];
		int unsigned        count;
		bit                 running;
		bit                 have_start;
		logic [31:0]        t_start;
		setpoint_t          expected_q[$];
		int                 errors;

		function new();
			count = 0;
			running = 0;
			have_start = 0;
			t_start = '0;
			errors = 0;
		endfunction

		// Interpolates one joint between two waypoints with weight w (Q1.30).
		function logic [30:0] blend(longint p0, longint p1, longint w);
			longint v;
			v = p0 + (((p1 - p0) * w + (longint'(1) << 29)) >>> 30);
			while (v < 0)
				v += longint'(TwoPiQ28);
			return v[30:0];
		endfunction

		function void note_beat(logic f, logic [5:0] idx, logic last, logic [31:0] pt,
				logic signed [31:0] pa, logic signed [31:0] pb, logic signed [31:0] pc,
				logic [31:0] now);
			setpoint_t r;
			logic [31:0] elapsed;
			int unsigned seg;
			longint t0, t1, num, dur, w;
			if (f == FUNC_LOAD) begin
				wp_time[idx] = pt;
				wp_pos[idx][0] = pa;
				wp_pos[idx][1] = pb;
				wp_pos[idx][2] = pc;
				if (last) begin
					count = idx + 1;
					running = 1;
					have_start = 0;
				end
				return;
			end
			r = '0;
			if (running) begin
				if (!have_start) begin
					t_start = now;
					have_start = 1;
				end
				elapsed = now - t_start;
				seg = 1;
				while (seg < count && wp_time[seg] < elapsed)
					seg++;
				if (seg >= count) begin
					r.status = STATUS_DONE;
					running = 0;
					have_start = 0;
				end else begin
					t0 = longint'(wp_time[seg-1]);
					t1 = longint'(wp_time[seg]);
					num = longint'(elapsed) - t0;
					dur = t1 - t0;
					if (dur <= 0 || num >= dur)
						w = longint'(1) << 30;
					else if (num <= 0)
						w = 0;
					else
						w = (num << 30) / dur;
					r.status = STATUS_SETPOINT;
					r.segment = seg[5:0];
					r.sp_a = blend(wp_pos[seg-1][0], wp_pos[seg][0], w);
					r.sp_b = blend(wp_pos[seg-1][1], wp_pos[seg][1], w);
					r.sp_c = blend(wp_pos[seg-1][2], wp_pos[seg][2], w);
				end
			end
			expected_q.push_back(r);
		endfunction

		function void check_beat(setpoint_t got);
			setpoint_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result beat: status %0d", got.status);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got.status);
				errors++;
			end
			if (got.segment !== e.segment) begin
				$error("segment: expected %0d, got %0d", e.segment, got.segment);
				errors++;
			end
			if (got.sp_a !== e.sp_a) begin
				$error("setpoint_a: expected %0d, got %0d", e.sp_a, got.sp_a);
				errors++;
			end
			if (got.sp_b !== e.sp_b) begin
				$error("setpoint_b: expected %0d, got %0d", e.sp_b, got.sp_b);
				errors++;
			end
			if (got.sp_c !== e.sp_c) begin
				$error("setpoint_c: expected %0d, got %0d", e.sp_c, got.sp_c);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               func;
	logic [IdxW-1:0]    point_index;
	logic               point_last;
	logic [31:0]        point_time;
	logic signed [31:0] point_pos_a;
	logic signed [31:0] point_pos_b;
	logic signed [31:0] point_pos_c;
	logic [31:0]        now_time;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic [IdxW-1:0]    segment;
	logic [30:0]        setpoint_a;
	logic [30:0]        setpoint_b;
	logic [30:0]        setpoint_c;

	setpoint_scoreboard sb = new();
	bit calm;
	bit written[MaxPoints];
	int sent;

	trajectory_linear_interpolator i_dut (.*);

	always #6 clk = ~clk;

	// The receiver stalls at random except during the calm stretch.
	always @(negedge clk) begin
		out_stall = !calm && ($urandom_range(99) < 35);
	end

	// Every result beat is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_beat({status, segment, setpoint_a, setpoint_b, setpoint_c});
	end

	// Sends one beat with random idle cycles ahead of it.
	task automatic send_beat(logic f, logic [5:0] idx, logic last, logic [31:0] pt,
			logic [31:0] pa, logic [31:0] pb, logic [31:0] pc, logic [31:0] now);
		while (!calm && $urandom_range(99) < 35) begin
			in_valid = 0;
			@(negedge clk);
		end
		func = f;
		point_index = idx;
		point_last = last;
		point_time = pt;
		point_pos_a = pa;
		point_pos_b = pb;
		point_pos_c = pc;
		now_time = now;
		in_valid = 1;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_beat(f, idx, last, pt, pa, pb, pc, now);
		if (f == FUNC_LOAD)
			written[idx] = 1;
		sent++;
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic load(logic [5:0] idx, logic last, logic [31:0] pt,
			logic [31:0] pa, logic [31:0] pb, logic [31:0] pc);
		send_beat(FUNC_LOAD, idx, last, pt, pa, pb, pc, $urandom);
	endtask

	task automatic tick(logic [31:0] now);
		send_beat(FUNC_TICK, 6'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
			$urandom, now);
	endtask

	task automatic drain();
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	// Noise loads may only mark a slot last once every slot below it is loaded.
	function automatic bit may_finish(int idx);
		for (int k = 0; k < idx; k++)
			if (!written[k])
				return 0;
		return 1;
	endfunction

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int n;
		int idx;
		logic [31:0] t;
		logic [31:0] now;
		logic [31:0] span;
		clk = 0;
		arst_n = 0;
		in_valid = 0;
		func = FUNC_LOAD;
		point_index = '0;
		point_last = 0;
		point_time = '0;
		point_pos_a = '0;
		point_pos_b = '0;
		point_pos_c = '0;
		now_time = '0;
		calm = 0;
		sent = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: no trajectory, single waypoint, degenerate segments, time wrap.
		tick(32'h0);
		load(0, 1, 32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h0);
		tick(32'hFFFFFFFF);
		tick(32'h12345678);
		load(0, 0, 32'd100, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
		load(1, 0, 32'd100, 32'h7FFFFFFF, 32'h80000000, 32'h10000000);
		load(2, 0, 32'd50, 32'h80000000, 32'h00000001, 32'hF0000000);
		load(3, 1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h55555555);
		tick(32'hFFFFFFF0);
		tick(32'h0000002C);
		tick(32'h00000055);
		tick(32'hFFFFFFEF);
		load(63, 0, 32'hAAAAAAAA, 32'h12345678, 32'h9ABCDEF0, 32'hDEADBEEF);
		load(0, 0, 32'd100, 32'hC0000000, 32'h40000000, 32'h00000000);
		// Marking slot 1 last while active restarts the trajectory.
		load(1, 1, 32'd2000, 32'h40000000, 32'hC0000000, 32'h7FFFFFFF);
		tick(32'd5);
		tick(32'd1005);
		tick(32'd2005);
		tick(32'd2006);
		tick(32'd2007);

		// The sender holds off until every outstanding result has arrived.
		drain();

		// Random: well-formed trajectories with random content, plus stray beats.
		while (sent < 440) begin
			calm = (sent > 200 && sent < 280);
			if ($urandom_range(99) < 15) begin
				idx = $urandom_range(63);
				if ($urandom_range(1))
					tick($urandom);
				else
					load(6'(idx), may_finish(idx) && $urandom_range(1), $urandom,
						$urandom, $urandom, $urandom);
				continue;
			end
			n = ($urandom_range(9) == 0) ? $urandom_range(2, 64) : $urandom_range(1, 6);
			t = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 500);
			for (int k = 0; k < n; k++) begin
				case ($urandom_range(9))
					0: t = t;
					1: t = t - $urandom_range(0, 200);
					2: t = $urandom;
					default: t = t + $urandom_range(1, 1000);
				endcase
				load(6'(k), k == n - 1, t, $urandom, $urandom, $urandom);
			end
			span = t;
			now = $urandom;
			for (int k = 0; k < 12 && sb.running; k++) begin
				tick(now);
				now = now + $urandom_range(0, span / 4 + 200);
			end
			if (sb.running)
				tick(sb.t_start + 32'hFFFFFFFF);
		end
		calm = 0;
		drain();

		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ filelist.f @@
design/tli_pkg.sv
design/trajectory_linear_interpolator.sv
tb/sv/tb_trajectory_linear_interpolator.sv
